// File: rtl/rnb_pkg.sv
// ---------------------------------------------------------------------------
// rnb_pkg: shared types and constants for the RGB neighbour blur
// Beat layouts, window column type, configuration codes and the blur sum.
// ---------------------------------------------------------------------------
package rnb_pkg;

  localparam int FW_W       = 11;
  localparam int FH_W       = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int OUT_COL_W  = 10;
  localparam int OUT_ROW_W  = 16;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = 3;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } pix_in_t;

  typedef struct packed {
    logic [OUT_COL_W-1:0] out_col;
    logic [OUT_ROW_W-1:0] out_row;
    logic [7:0]           out_red;
    logic [7:0]           out_green;
    logic [7:0]           out_blue;
    logic                 last_of_run;
  } result_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // one window column: top = row y-2, mid = row y-1, bot = row y
  typedef struct packed {
    rgb_t top;
    rgb_t mid;
    rgb_t bot;
  } col_t;

  // the two line stores at one column
  typedef struct packed {
    rgb_t two;
    rgb_t one;
  } line_pair_t;

  typedef struct packed {
    logic              room;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  function automatic logic [7:0] sh3(input logic [7:0] v);
    return {3'b000, v[7:3]};
  endfunction

  // eight neighbours, each divided by 8; the center (a.mid) is left out
  function automatic rgb_t blur_px(input col_t b, input col_t a, input col_t n);
    rgb_t o;
    o.red   = sh3(b.top.red) + sh3(b.mid.red) + sh3(b.bot.red) + sh3(a.top.red)
            + sh3(a.bot.red) + sh3(n.top.red) + sh3(n.mid.red) + sh3(n.bot.red);
    o.green = sh3(b.top.green) + sh3(b.mid.green) + sh3(b.bot.green)
            + sh3(a.top.green) + sh3(a.bot.green) + sh3(n.top.green)
            + sh3(n.mid.green) + sh3(n.bot.green);
    o.blue  = sh3(b.top.blue) + sh3(b.mid.blue) + sh3(b.bot.blue) + sh3(a.top.blue)
            + sh3(a.bot.blue) + sh3(n.top.blue) + sh3(n.mid.blue) + sh3(n.bot.blue);
    return o;
  endfunction

endpackage

// File: rtl/rnb_cell.sv
// ---------------------------------------------------------------------------
// rnb_cell: one column of the 3x3 window
// Holds three pixels and takes the column of its right neighbor on shift.
// ---------------------------------------------------------------------------
module rnb_cell
  import rnb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic shift,
  input  col_t col_in,
  output col_t col_out
);

  col_t col;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
    end else if (shift) begin
      col <= col_in;
    end
  end

  assign col_out = col;

endmodule

// File: rtl/rnb_line_buf.sv
// ---------------------------------------------------------------------------
// rnb_line_buf: the two previous rows of the frame
// One write and one registered read per cycle; a read of the column being
// written in the same cycle returns the new data.
// ---------------------------------------------------------------------------
module rnb_line_buf
  import rnb_pkg::*;
#(
  parameter int Depth = 1024,
  parameter int AddrW = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  line_pair_t       wr_data,
  output line_pair_t       rd_data
);

  rgb_t       two_mem [Depth];
  rgb_t       one_mem [Depth];
  line_pair_t rd_q;
  line_pair_t byp_q;
  logic       byp;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      two_mem[wr_addr] <= wr_data.two;
      one_mem[wr_addr] <= wr_data.one;
    end
    if (rd_en) begin
      rd_q.two <= two_mem[rd_addr];
      rd_q.one <= one_mem[rd_addr];
      byp_q    <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else if (rd_en) begin
      byp <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = byp ? byp_q : rd_q;

endmodule

// File: rtl/rnb_out_queue.sv
// ---------------------------------------------------------------------------
// rnb_out_queue: result queue
// Takes up to two beats per cycle; delivers one per cycle unless stalled.
// ---------------------------------------------------------------------------
module rnb_out_queue
  import rnb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_n,
  input  result_t    beat0,
  input  result_t    beat1,
  output logic       q_valid,
  input  logic       q_stall,
  output result_t    q_head,
  output q_stat_t    stat
);

  result_t           mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              pop;

  assign q_valid = (count != '0);
  assign q_head  = mem[rd_ptr];
  assign pop     = q_valid && !q_stall;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= beat0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr + QPTR_W'(1)] <= beat1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push_n);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count + QCNT_W'(push_n) - QCNT_W'(pop);
    end
  end

  // room for a full pair of beats
  assign stat.room  = (count <= QCNT_W'(QDEPTH - 2));
  assign stat.count = count;

endmodule

// File: rtl/rgb_neighbour_blur_3x3_top.sv
// ---------------------------------------------------------------------------
// rgb_neighbour_blur_3x3_top: streaming 3x3 eight-neighbour RGB blur
//
//   channel | direction | handshake              | beat
//   pix     | in        | pix_valid / pix_stall  | pix_in_t: one raster pixel
//   res     | out       | res_valid / res_stall  | result_t: one output pixel
//   cfg     | in        | cfg_we                 | cfg_idx, cfg_data
//
// One pixel enters per cycle while the queue has room for a pair of beats. A
// pixel that yields two results (an interior result plus its own border copy)
// takes two output beats; the single-beat queue head sets the sustained rate.
// An accepted pixel waits in the window stage register until its results enter the queue.
// Reset is synchronous; no clearing pass: line stores fill as rows arrive.
// Once three beats wait in the four-beat queue, hold the window stage and stall input.
// ---------------------------------------------------------------------------
module rgb_neighbour_blur_3x3_top
  import rnb_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pix_valid,
  output logic                  pix_stall,
  input  pix_in_t               pix,
  output logic                  res_valid,
  input  logic                  res_stall,
  output result_t               res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = (CW + 1 > FW_W) ? CW + 1 : FW_W;

  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;
  logic [CW-1:0]   column_count;
  logic [15:0]     row_count;

  logic [EW-1:0] fw_ext;
  logic [EW-1:0] w_eff;
  logic [15:0]   h_eff;
  logic [EW-1:0] col_p1;
  logic [16:0]   row_p1;
  logic          last_col;
  logic          last_row;
  logic          border_now;
  logic          blur_now;
  logic          accept;

  logic          s1_valid;
  logic          s1_go;
  rgb_t          s1_px;
  logic [CW-1:0] s1_x;
  logic [15:0]   s1_y;
  logic          s1_blur;
  logic          s1_border;

  line_pair_t lb_rd;
  line_pair_t lb_wr;
  col_t       new_col;
  col_t       cell_a;
  col_t       cell_b;
  rgb_t       blur;

  result_t    blur_beat;
  result_t    border_beat;
  logic [1:0] push_n;
  q_stat_t    q_stat;

  // effective frame size
  assign fw_ext = EW'(frame_width);
  assign w_eff  = (fw_ext == '0) ? EW'(1) :
                  (fw_ext > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : fw_ext;
  assign h_eff  = (frame_height == '0) ? 16'd1 : frame_height;

  assign col_p1     = EW'(column_count) + EW'(1);
  assign row_p1     = {1'b0, row_count} + 17'd1;
  assign last_col   = (col_p1 >= w_eff);
  assign last_row   = (row_p1 >= {1'b0, h_eff});
  assign border_now = (column_count == '0) || (row_count == '0) ||
                      (col_p1 == w_eff) || (row_p1 == {1'b0, h_eff});
  assign blur_now   = (column_count >= CW'(2)) && (row_count >= 16'd2);

  assign s1_go     = s1_valid && q_stat.room;
  assign pix_stall = s1_valid && !q_stat.room;
  assign accept    = pix_valid && !pix_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      column_count <= '0;
      row_count    <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        default: ;
      endcase
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? 16'd0 : row_p1[15:0];
      end else begin
        column_count <= col_p1[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px     <= '{red: pix.in_red, green: pix.in_green, blue: pix.in_blue};
      s1_x      <= column_count;
      s1_y      <= row_count;
      s1_blur   <= blur_now;
      s1_border <= border_now;
    end
  end

  // roll the two row stores down by one row at this column
  assign lb_wr.two = lb_rd.one;
  assign lb_wr.one = s1_px;

  rnb_line_buf #(
    .Depth (MAX_WIDTH),
    .AddrW (CW)
  ) u_line_buf (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (column_count),
    .wr_en   (s1_go),
    .wr_addr (s1_x),
    .wr_data (lb_wr),
    .rd_data (lb_rd)
  );

  assign new_col = '{top: lb_rd.two, mid: lb_rd.one, bot: s1_px};

  rnb_cell u_cell_a (
    .clk     (clk),
    .rst     (rst),
    .shift   (s1_go),
    .col_in  (new_col),
    .col_out (cell_a)
  );

  rnb_cell u_cell_b (
    .clk     (clk),
    .rst     (rst),
    .shift   (s1_go),
    .col_in  (cell_a),
    .col_out (cell_b)
  );

  assign blur = blur_px(cell_b, cell_a, new_col);

  always_comb begin
    blur_beat.out_col     = OUT_COL_W'(s1_x - CW'(1));
    blur_beat.out_row     = s1_y - 16'd1;
    blur_beat.out_red     = blur.red;
    blur_beat.out_green   = blur.green;
    blur_beat.out_blue    = blur.blue;
    blur_beat.last_of_run = !s1_border;

    border_beat.out_col     = OUT_COL_W'(s1_x);
    border_beat.out_row     = s1_y;
    border_beat.out_red     = s1_px.red;
    border_beat.out_green   = s1_px.green;
    border_beat.out_blue    = s1_px.blue;
    border_beat.last_of_run = 1'b1;

    push_n = s1_go ? ({1'b0, s1_blur} + {1'b0, s1_border}) : 2'd0;
  end

  rnb_out_queue u_out_queue (
    .clk     (clk),
    .rst     (rst),
    .push_n  (push_n),
    .beat0   (s1_blur ? blur_beat : border_beat),
    .beat1   (border_beat),
    .q_valid (res_valid),
    .q_stall (res_stall),
    .q_head  (res),
    .stat    (q_stat)
  );

  a_stage_fill : assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted pixel did not reach the window stage");

  a_pair_kept : assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.last_of_run |=> res_valid)
    else $error("interior result not followed by its border copy");

  a_queue_bound : assert property (@(posedge clk) disable iff (rst)
    q_stat.count <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

endmodule

// File: bench/tb_rgb_neighbour_blur_3x3_top.sv
// ---------------------------------------------------------------------------
// tb_rgb_neighbour_blur_3x3_top: self-checking bench for the RGB neighbour blur
// Streams raster pixels through frames of several sizes and predicts every
// border copy and interior blur beat. The bench compares each result beat,
// field by field, against the predicted beats in order. Random idle bursts
// are applied on both channels.
// ---------------------------------------------------------------------------
module tb_rgb_neighbour_blur_3x3_top;
  import rnb_pkg::*;

  localparam int MAX_W       = 1024;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 450;
  localparam int SETTLE_CYCLES = 8;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  pix_valid = 1'b0;
  logic                  pix_stall;
  pix_in_t               pix = '0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  result_t               res;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = CFG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rgb_neighbour_blur_3x3_top #(.MAX_WIDTH(MAX_W)) u_top (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // blur state: line stores, 3x3 window, raster position, frame size
  logic [23:0]      line_two_q[MAX_W];
  logic [23:0]      line_one_q[MAX_W];
  logic [23:0]      win[9];
  int unsigned      cur_col;
  int unsigned      cur_row;
  logic [FW_W-1:0]  width_reg;
  logic [FH_W-1:0]  height_reg;

  pix_in_t     pixel_queue[$];
  result_t     expected_results[$];
  int unsigned pixels_offered = 0;
  int unsigned pixels_taken = 0;
  int unsigned results_seen = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_pct = 25;
  bit          calm = 1'b0;
  int          pix_gap = 0;
  int          res_gap = 0;

  function automatic void blur_reset();
    for (int i = 0; i < MAX_W; i++) begin
      line_two_q[i] = '0;
      line_one_q[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
    cur_col = 0;
    cur_row = 0;
    width_reg = FRAME_WIDTH_RST;
    height_reg = FRAME_HEIGHT_RST;
  endfunction

  // sum of the eight neighbours, each divided by 8, for one channel
  function automatic logic [7:0] neighbour_sum(input int sh);
    int unsigned acc;
    acc = 0;
    for (int i = 0; i < 9; i++)
      if (i != 4) acc += ((win[i] >> sh) & 24'hFF) >> 3;
    return acc[7:0];
  endfunction

  function automatic void blur_predict(input pix_in_t p);
    logic [23:0] cur;
    logic [23:0] above;
    logic [23:0] above2;
    result_t     beats[2];
    int unsigned w;
    int unsigned h;
    int unsigned x;
    int unsigned y;
    int          n;
    cur = {p.in_red, p.in_green, p.in_blue};
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : width_reg);
    h = (height_reg == 0) ? 1 : height_reg;
    x = cur_col;
    y = cur_row;
    n = 0;
    above2 = line_two_q[x];
    above = line_one_q[x];
    line_two_q[x] = above;
    line_one_q[x] = cur;
    for (int r = 0; r < 3; r++) begin
      win[r*3] = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = above2;
    win[5] = above;
    win[8] = cur;
    if (x >= 2 && y >= 2) begin
      beats[n].out_col = OUT_COL_W'(x - 1);
      beats[n].out_row = OUT_ROW_W'(y - 1);
      beats[n].out_red = neighbour_sum(16);
      beats[n].out_green = neighbour_sum(8);
      beats[n].out_blue = neighbour_sum(0);
      beats[n].last_of_run = 1'b0;
      n++;
    end
    if (x == 0 || y == 0 || x + 1 == w || y + 1 == h) begin
      beats[n].out_col = OUT_COL_W'(x);
      beats[n].out_row = OUT_ROW_W'(y);
      beats[n].out_red = p.in_red;
      beats[n].out_green = p.in_green;
      beats[n].out_blue = p.in_blue;
      beats[n].last_of_run = 1'b0;
      n++;
    end
    if (n > 0) beats[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) expected_results.push_back(beats[i]);
    if (x + 1 >= w) begin
      cur_col = 0;
      cur_row = (y + 1 >= h) ? 0 : y + 1;
    end else begin
      cur_col = x + 1;
    end
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    error_count++;
    if (error_count <= 100)
      $display("mismatch at result %0d: %s got %0d want %0d",
               results_seen, what, got, want);
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected beat, col", got.out_col, 0);
    end else begin
      want = expected_results.pop_front();
      if (got.out_col !== want.out_col) report_mismatch("out_col", got.out_col, want.out_col);
      if (got.out_row !== want.out_row) report_mismatch("out_row", got.out_row, want.out_row);
      if (got.out_red !== want.out_red) report_mismatch("out_red", got.out_red, want.out_red);
      if (got.out_green !== want.out_green)
        report_mismatch("out_green", got.out_green, want.out_green);
      if (got.out_blue !== want.out_blue)
        report_mismatch("out_blue", got.out_blue, want.out_blue);
      if (got.last_of_run !== want.last_of_run)
        report_mismatch("last_of_run", got.last_of_run, want.last_of_run);
    end
    results_seen++;
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    cycle_count++;
    if (!rst) begin
      if (pix_valid && !pix_stall) begin
        blur_predict(pix);
        pixels_taken++;
      end
      if (res_valid && !res_stall) check_result(res);
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_rgb_neighbour_blur_3x3_top: errors");
      $finish;
    end
  end

  // pixel driver: hold a beat until taken, then advance or idle
  always @(negedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (!(pix_valid && pixels_taken != pixels_offered)) begin
      if (pix_gap > 0) begin
        pix_gap--;
        pix_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
        pix_gap = $urandom_range(0, 4);
        pix_valid <= 1'b0;
      end else if (pixel_queue.size() != 0) begin
        pix <= pixel_queue.pop_front();
        pix_valid <= 1'b1;
        pixels_offered++;
      end else begin
        pix_valid <= 1'b0;
      end
    end
  end

  // result stall driver
  always @(negedge clk) begin
    if (rst || calm) begin
      res_gap = 0;
      res_stall <= 1'b0;
    end else if (res_gap > 0) begin
      res_gap--;
      res_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      res_gap = $urandom_range(0, 4);
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  task automatic wait_drained();
    while (pixel_queue.size() != 0 || pixels_taken != pixels_offered ||
           expected_results.size() != 0)
      @(negedge clk);
    // a pixel with no result may still be in flight
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    if (idx == CFG_FRAME_WIDTH) width_reg = data[FW_W-1:0];
    else height_reg = data[FH_W-1:0];
    cur_col = 0;
    cur_row = 0;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic pix_in_t random_pixel();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return pix_in_t'($urandom());
  endfunction

  initial begin
    int unsigned random_sent;
    int unsigned n;
    int unsigned w_val;
    int unsigned h_val;
    int unsigned sel;
    int          phase;
    pix_in_t     p;
    blur_reset();
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // reset frame size: a few top-row pixels, then restart mid-row
    pixel_queue.push_back('0);
    pixel_queue.push_back('1);
    pixel_queue.push_back(pix_in_t'(24'hA5_5A_C3));
    pixel_queue.push_back(pix_in_t'(24'h3C_96_69));
    wait_drained();

    // 3x3 frame of full white around a black center: blur saturates at 248
    write_reg(CFG_FRAME_WIDTH, 3);
    write_reg(CFG_FRAME_HEIGHT, 3);
    for (int i = 0; i < 9; i++) pixel_queue.push_back(i == 4 ? pix_in_t'('0) : pix_in_t'('1));
    // next frame: mixed channels, bright center must not leak into the sum
    for (int i = 0; i < 9; i++)
      pixel_queue.push_back(i == 4 ? pix_in_t'(24'h00_FF_FF) : pix_in_t'(24'hFF_07_08));
    wait_drained();

    // zero sizes act as one
    write_reg(CFG_FRAME_WIDTH, 0);
    write_reg(CFG_FRAME_HEIGHT, 0);
    pixel_queue.push_back(pix_in_t'(24'h12_34_56));
    pixel_queue.push_back(pix_in_t'(24'hED_CB_A9));
    wait_drained();

    // width beyond the line store clamps to its depth; run past one wrap
    idle_pct = 15;
    write_reg(CFG_FRAME_WIDTH, 2047);
    write_reg(CFG_FRAME_HEIGHT, 1);
    for (int i = 0; i < MAX_W + 6; i++) pixel_queue.push_back(random_pixel());
    wait_drained();

    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 2);
      if ($urandom_range(0, 11) == 0) w_val = MAX_W;
      else w_val = $urandom_range(0, 9);
      case ($urandom_range(0, 7))
        6: h_val = 0;
        7: h_val = 16'hFFFF;
        default: h_val = $urandom_range(1, 6);
      endcase
      if (sel != 2) write_reg(CFG_FRAME_WIDTH, w_val);
      if (sel != 1) write_reg(CFG_FRAME_HEIGHT, h_val);
      n = $urandom_range(10, 50);
      idle_pct = (phase % 4 == 1) ? 0 : 30;
      calm = (random_sent >= RANDOM_ITEMS - 80);
      for (int i = 0; i < n; i++) begin
        p = random_pixel();
        pixel_queue.push_back(p);
        // hold the source once mid-frame until every result is back
        if (phase == 0 && i == n / 2) wait_drained();
      end
      random_sent += n;
      phase++;
      wait_drained();
    end

    if (expected_results.size() != 0)
      report_mismatch("results never seen", expected_results.size(), 0);
    if (error_count == 0) begin
      $display("tb_rgb_neighbour_blur_3x3_top: clean");
    end else begin
      $display("tb_rgb_neighbour_blur_3x3_top: errors");
    end
    $finish;
  end

endmodule
